@@ rtl/core/complex_arithmetic_unit_macros.svh @@
// ----------------------------------------------------------------------------
// Complex arithmetic unit assertion macros
// Shorthand for clocked assertions that are disabled while reset is asserted.
// ----------------------------------------------------------------------------
`ifndef COMPLEX_ARITHMETIC_UNIT_MACROS_SVH
`define COMPLEX_ARITHMETIC_UNIT_MACROS_SVH

// A plain clocked property.
`define CAU_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// An implication in the same cycle.
`define CAU_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`endif

@@ rtl/core/cau_pkg.sv @@
// ----------------------------------------------------------------------------
// Complex arithmetic unit package
// Widths, codes, pipeline structs and the saturation helpers.
// ----------------------------------------------------------------------------
package cau_pkg;

  localparam int DATA_W  = 16;
  localparam int FRAC_W  = 8;
  localparam int PROD_W  = 2 * DATA_W;
  localparam int SUM_W   = PROD_W + 1;
  // One cell per quotient bit; the quotient before rounding stays below 2^NCELL.
  localparam int NCELL   = DATA_W + 2;
  localparam int DVS_W   = PROD_W + FRAC_W;
  localparam int REM_W   = DVS_W + 1;
  localparam int SQ_W    = 2 * NCELL;
  localparam int SR_W    = NCELL;
  localparam int CLAMP_W = PROD_W - FRAC_W;

  localparam logic [CLAMP_W-1:0] NEG_LIM = CLAMP_W'(1) << (DATA_W - 1);
  localparam logic [CLAMP_W-1:0] POS_LIM = NEG_LIM - CLAMP_W'(1);
  localparam logic signed [DATA_W-1:0] MAX_POS = {1'b0, {(DATA_W-1){1'b1}}};
  localparam logic signed [DATA_W-1:0] MIN_NEG = {1'b1, {(DATA_W-1){1'b0}}};

  typedef enum logic [2:0] {
    OP_ADD = 3'd0,
    OP_SUB = 3'd1,
    OP_MUL = 3'd2,
    OP_DIV = 3'd3,
    OP_MAG = 3'd4,
    OP_CMP = 3'd5
  } op_e;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_SAT  = 2'd1,
    ST_DIV0 = 2'd2
  } st_e;

  // Data that rides along the cell chain untouched.
  typedef struct packed {
    op_e                      op;
    logic signed [DATA_W-1:0] re;
    logic signed [DATA_W-1:0] im;
    logic                     eq;
    logic                     sat;
    logic                     div0;
    logic                     neg_re;
    logic                     neg_im;
    logic                     ovf_re;
    logic                     ovf_im;
  } side_t;

  // Everything one cell hands to the next.
  typedef struct packed {
    side_t              side;
    logic [REM_W-1:0]   rem_re;
    logic [REM_W-1:0]   rem_im;
    logic [NCELL-1:0]   q_re;
    logic [NCELL-1:0]   q_im;
    logic [DVS_W-1:0]   dvs;
    logic [SQ_W-1:0]    sq_src;
    logic [SR_W-1:0]    sq_rem;
    logic [NCELL-1:0]   sq_root;
  } cell_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] re;
    logic signed [DATA_W-1:0] im;
    logic                     eq;
    st_e                      st;
  } res_t;

  // Clamp a sign/magnitude value to the signed data range; MSB flags saturation.
  function automatic logic [DATA_W:0] sat_clamp(input logic neg,
                                                input logic [CLAMP_W-1:0] mag);
    logic [DATA_W:0]    r;
    logic [CLAMP_W-1:0] nm;
    nm = ~mag + CLAMP_W'(1);
    if (!neg) begin
      if (mag > POS_LIM) r = {1'b1, MAX_POS};
      else               r = {1'b0, mag[DATA_W-1:0]};
    end else begin
      if (mag > NEG_LIM) r = {1'b1, MIN_NEG};
      else               r = {1'b0, nm[DATA_W-1:0]};
    end
    return r;
  endfunction

  // Round a quotient that carries one extra fraction bit, then clamp.
  function automatic logic [DATA_W:0] div_lane(input logic ovf, input logic neg,
                                               input logic [NCELL-1:0] q);
    logic [NCELL:0]   qs;
    logic [NCELL-1:0] qr;
    logic [DATA_W:0]  r;
    qs = {1'b0, q} + (NCELL+1)'(1);
    qr = qs[NCELL:1];
    if (ovf) r = sat_clamp(neg, {CLAMP_W{1'b1}});
    else     r = sat_clamp(neg && (qr != '0), CLAMP_W'(qr));
    return r;
  endfunction

endpackage

@@ rtl/core/complex_arithmetic_unit.sv @@
// ----------------------------------------------------------------------------
// Complex arithmetic unit
// Add, subtract, multiply, divide, magnitude and compare on Q8.8 pairs.
// ----------------------------------------------------------------------------
// The unit takes one beat per cycle while in_stall_o is low. Each accepted beat
// passes three front stages (products, sums, divider setup), a chain of 18
// cells that each settle one quotient bit of both divider lanes and one bit of
// the square root, and the output register where the quotient and the root are
// rounded and clamped. Every operation walks the same path, so results leave in
// order. A skid register behind the output lets the pipeline take one more beat
// while a result is stalled; in_stall_o rises only when that skid register is
// full.
`include "complex_arithmetic_unit_macros.svh"

module complex_arithmetic_unit import cau_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  logic [2:0]               req_type_i,
  input  logic signed [DATA_W-1:0] a_re_i,
  input  logic signed [DATA_W-1:0] a_im_i,
  input  logic signed [DATA_W-1:0] b_re_i,
  input  logic signed [DATA_W-1:0] b_im_i,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output logic signed [DATA_W-1:0] res_re_o,
  output logic signed [DATA_W-1:0] res_im_o,
  output logic                     is_equal_o,
  output logic [1:0]               status_o
);

  logic  en;
  logic  chain_v [0:NCELL];
  cell_t chain_d [0:NCELL];

  logic  out_valid_q, skid_full_q;
  res_t  out_q, skid_q, fin;

  assign en = !skid_full_q;

  // Front stages.
  cau_prep u_prep (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .en_i       (en),
    .valid_i    (in_valid_i),
    .req_type_i (req_type_i),
    .a_re_i     (a_re_i),
    .a_im_i     (a_im_i),
    .b_re_i     (b_re_i),
    .b_im_i     (b_im_i),
    .valid_o    (chain_v[0]),
    .data_o     (chain_d[0])
  );

  // Divider and root chain.
  for (genvar i = 0; i < NCELL; i++) begin : g_cell
    cau_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .valid_i (chain_v[i]),
      .data_i  (chain_d[i]),
      .valid_o (chain_v[i+1]),
      .data_o  (chain_d[i+1])
    );
  end

  // Final rounding and result selection.
  cell_t           last;
  logic [DATA_W:0] d_re, d_im, mg;
  logic [NCELL:0]  root_r;

  always_comb begin
    last   = chain_d[NCELL];
    d_re   = div_lane(last.side.ovf_re, last.side.neg_re, last.q_re);
    d_im   = div_lane(last.side.ovf_im, last.side.neg_im, last.q_im);
    root_r = {1'b0, last.sq_root} + (NCELL+1)'(last.sq_rem > SR_W'(last.sq_root));
    mg     = sat_clamp(1'b0, CLAMP_W'(root_r));

    fin.re = last.side.re;
    fin.im = last.side.im;
    fin.eq = last.side.eq;
    fin.st = last.side.sat ? ST_SAT : ST_OK;
    case (last.side.op)
      OP_DIV: begin
        if (last.side.div0) begin
          fin.re = '0;
          fin.im = '0;
          fin.st = ST_DIV0;
        end else begin
          fin.re = d_re[DATA_W-1:0];
          fin.im = d_im[DATA_W-1:0];
          fin.st = (d_re[DATA_W] | d_im[DATA_W]) ? ST_SAT : ST_OK;
        end
      end
      OP_MAG: begin
        fin.re = mg[DATA_W-1:0];
        fin.im = '0;
        fin.st = mg[DATA_W] ? ST_SAT : ST_OK;
      end
      default: begin
        fin.eq = last.side.eq;
      end
    endcase
  end

  // Output register with a skid register behind it.
  logic take, exit_v;
  assign take   = out_valid_q && !out_stall_i;
  assign exit_v = chain_v[NCELL] && en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      skid_full_q <= 1'b0;
    end else if (skid_full_q) begin
      if (take) begin
        skid_full_q <= 1'b0;
      end
    end else if (exit_v) begin
      if (out_valid_q && !take) begin
        skid_full_q <= 1'b1;
      end else begin
        out_valid_q <= 1'b1;
      end
    end else if (take) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_full_q) begin
      if (take) begin
        out_q <= skid_q;
      end
    end else if (exit_v) begin
      if (out_valid_q && !take) begin
        skid_q <= fin;
      end else begin
        out_q <= fin;
      end
    end
  end

  assign in_stall_o  = skid_full_q;
  assign out_valid_o = out_valid_q;
  assign res_re_o    = out_q.re;
  assign res_im_o    = out_q.im;
  assign is_equal_o  = out_q.eq;
  assign status_o    = out_q.st;

  `CAU_ASSERT_IMPL(a_skid_has_out, skid_full_q, out_valid_q, "skid full while output empty")
  `CAU_ASSERT_IMPL(a_div0_zero, out_valid_q && out_q.st == ST_DIV0, out_q.re == '0 && out_q.im == '0 && !out_q.eq, "divide by zero beat not cleared")
  `CAU_ASSERT_IMPL(a_eq_clean, out_valid_q && out_q.eq, out_q.st == ST_OK && out_q.re == '0 && out_q.im == '0, "compare beat carries data")
  `CAU_ASSERT(a_skid_fill, $rose(skid_full_q) |-> $past(out_valid_q) && $past(out_stall_i), "skid filled without a stalled output")

endmodule

@@ rtl/core/cau_prep.sv @@
// ----------------------------------------------------------------------------
// Complex arithmetic unit front end
// Three stages: products, sums, and setup of the divider and root chain.
// ----------------------------------------------------------------------------
module cau_prep import cau_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     en_i,
  input  logic                     valid_i,
  input  logic [2:0]               req_type_i,
  input  logic signed [DATA_W-1:0] a_re_i,
  input  logic signed [DATA_W-1:0] a_im_i,
  input  logic signed [DATA_W-1:0] b_re_i,
  input  logic signed [DATA_W-1:0] b_im_i,
  output logic                     valid_o,
  output cell_t                    data_o
);

  localparam logic [PROD_W:0] HALF = (PROD_W+1)'((1 << FRAC_W) >> 1);

  function automatic logic [PROD_W-1:0] mag_of(input logic signed [SUM_W-1:0] v);
    logic [SUM_W-1:0] n;
    n = v[SUM_W-1] ? (~v + SUM_W'(1)) : v;
    return n[PROD_W-1:0];
  endfunction

  // Stage A registers.
  logic                     va_q;
  op_e                      op_a_q;
  logic signed [PROD_W-1:0] p_rr_q, p_ii_q, p_ri_q, p_ir_q;
  logic signed [PROD_W-1:0] sq_ar_q, sq_ai_q, sq_br_q, sq_bi_q;
  logic signed [DATA_W-1:0] as_re_q, as_im_q;
  logic                     as_sat_q, eq_a_q;

  // Stage B registers.
  logic                     vb_q;
  op_e                      op_b_q;
  logic signed [SUM_W-1:0]  nr_q, ni_q, pr_q, pi_q;
  logic [PROD_W-1:0]        den_q, mag2_q;
  logic signed [DATA_W-1:0] as_re_b_q, as_im_b_q;
  logic                     as_sat_b_q, eq_b_q;

  // Stage C registers.
  logic                     vc_q;
  cell_t                    cell_q, cell_d;

  // Add and subtract with saturation, straight from the input beat.
  logic signed [DATA_W:0]   s_re, s_im;
  logic                     sub;
  logic                     sat_re, sat_im;
  logic signed [DATA_W-1:0] v_re, v_im;

  always_comb begin
    sub    = (op_e'(req_type_i) == OP_SUB);
    s_re   = sub ? ((DATA_W+1)'(a_re_i) - (DATA_W+1)'(b_re_i))
                 : ((DATA_W+1)'(a_re_i) + (DATA_W+1)'(b_re_i));
    s_im   = sub ? ((DATA_W+1)'(a_im_i) - (DATA_W+1)'(b_im_i))
                 : ((DATA_W+1)'(a_im_i) + (DATA_W+1)'(b_im_i));
    sat_re = s_re[DATA_W] ^ s_re[DATA_W-1];
    sat_im = s_im[DATA_W] ^ s_im[DATA_W-1];
    v_re   = sat_re ? (s_re[DATA_W] ? MIN_NEG : MAX_POS) : s_re[DATA_W-1:0];
    v_im   = sat_im ? (s_im[DATA_W] ? MIN_NEG : MAX_POS) : s_im[DATA_W-1:0];
  end

  // Valid pipeline.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
      vb_q <= 1'b0;
      vc_q <= 1'b0;
    end else if (en_i) begin
      va_q <= valid_i;
      vb_q <= va_q;
      vc_q <= vb_q;
    end
  end

  // Stage A: the eight partial products.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      op_a_q   <= op_e'(req_type_i);
      p_rr_q   <= a_re_i * b_re_i;
      p_ii_q   <= a_im_i * b_im_i;
      p_ri_q   <= a_re_i * b_im_i;
      p_ir_q   <= a_im_i * b_re_i;
      sq_ar_q  <= a_re_i * a_re_i;
      sq_ai_q  <= a_im_i * a_im_i;
      sq_br_q  <= b_re_i * b_re_i;
      sq_bi_q  <= b_im_i * b_im_i;
      as_re_q  <= v_re;
      as_im_q  <= v_im;
      as_sat_q <= sat_re | sat_im;
      eq_a_q   <= (a_re_i == b_re_i) && (a_im_i == b_im_i);
    end
  end

  // Stage B: product sums, divisor and squared magnitude.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      op_b_q     <= op_a_q;
      pr_q       <= SUM_W'(p_rr_q) - SUM_W'(p_ii_q);
      pi_q       <= SUM_W'(p_ri_q) + SUM_W'(p_ir_q);
      nr_q       <= SUM_W'(p_rr_q) + SUM_W'(p_ii_q);
      ni_q       <= SUM_W'(p_ir_q) - SUM_W'(p_ri_q);
      den_q      <= unsigned'(sq_br_q) + unsigned'(sq_bi_q);
      mag2_q     <= unsigned'(sq_ar_q) + unsigned'(sq_ai_q);
      as_re_b_q  <= as_re_q;
      as_im_b_q  <= as_im_q;
      as_sat_b_q <= as_sat_q;
      eq_b_q     <= eq_a_q;
    end
  end

  // Stage C: round the product, set up the chain lanes and the side data.
  logic [PROD_W-1:0] m_pr, m_pi, m_nr, m_ni;
  logic [PROD_W:0]   r_pr, r_pi;
  logic [DATA_W:0]   c_re, c_im;

  always_comb begin
    m_pr = mag_of(pr_q);
    m_pi = mag_of(pi_q);
    m_nr = mag_of(nr_q);
    m_ni = mag_of(ni_q);
    r_pr = {1'b0, m_pr} + HALF;
    r_pi = {1'b0, m_pi} + HALF;
    c_re = sat_clamp(pr_q[SUM_W-1] && (r_pr[FRAC_W +: CLAMP_W] != '0),
                     r_pr[FRAC_W +: CLAMP_W]);
    c_im = sat_clamp(pi_q[SUM_W-1] && (r_pi[FRAC_W +: CLAMP_W] != '0),
                     r_pi[FRAC_W +: CLAMP_W]);

    cell_d             = '0;
    cell_d.side.op     = op_b_q;
    cell_d.side.div0   = (den_q == '0);
    cell_d.side.neg_re = nr_q[SUM_W-1];
    cell_d.side.neg_im = ni_q[SUM_W-1];
    cell_d.side.ovf_re = ({{(FRAC_W+1){1'b0}}, m_nr} >= {den_q, {(FRAC_W+1){1'b0}}});
    cell_d.side.ovf_im = ({{(FRAC_W+1){1'b0}}, m_ni} >= {den_q, {(FRAC_W+1){1'b0}}});
    cell_d.rem_re      = {{(FRAC_W+1){1'b0}}, m_nr};
    cell_d.rem_im      = {{(FRAC_W+1){1'b0}}, m_ni};
    cell_d.dvs         = {den_q, {FRAC_W{1'b0}}};
    cell_d.sq_src      = SQ_W'(mag2_q);

    case (op_b_q)
      OP_ADD, OP_SUB: begin
        cell_d.side.re  = as_re_b_q;
        cell_d.side.im  = as_im_b_q;
        cell_d.side.sat = as_sat_b_q;
      end
      OP_MUL: begin
        cell_d.side.re  = c_re[DATA_W-1:0];
        cell_d.side.im  = c_im[DATA_W-1:0];
        cell_d.side.sat = c_re[DATA_W] | c_im[DATA_W];
      end
      OP_CMP: begin
        cell_d.side.eq  = eq_b_q;
      end
      default: begin
        cell_d.side.sat = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      cell_q <= cell_d;
    end
  end

  assign valid_o = vc_q;
  assign data_o  = cell_q;

endmodule

@@ rtl/core/cau_cell.sv @@
// ----------------------------------------------------------------------------
// Complex arithmetic unit chain cell
// One restoring quotient bit per lane, one square root bit per enabled cycle.
// ----------------------------------------------------------------------------
module cau_cell import cau_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  en_i,
  input  logic  valid_i,
  input  cell_t data_i,
  output logic  valid_o,
  output cell_t data_o
);

  logic           valid_q;
  cell_t          data_q, data_d;

  logic [REM_W-1:0] dvs_x, diff_re, diff_im;
  logic             ge_re, ge_im;
  logic [SR_W+1:0]  cur, trial, srem;
  logic             sge;

  always_comb begin
    // Divider lanes: subtract the scaled divisor when it fits, then shift.
    dvs_x   = {1'b0, data_i.dvs};
    ge_re   = (data_i.rem_re >= dvs_x);
    ge_im   = (data_i.rem_im >= dvs_x);
    diff_re = data_i.rem_re - (ge_re ? dvs_x : '0);
    diff_im = data_i.rem_im - (ge_im ? dvs_x : '0);

    // Square root: bring down two bits and try the next root bit.
    cur   = {data_i.sq_rem, data_i.sq_src[SQ_W-1 -: 2]};
    trial = {data_i.sq_root, 2'b01};
    sge   = (cur >= trial);
    srem  = sge ? (cur - trial) : cur;

    data_d         = data_i;
    data_d.rem_re  = {diff_re[REM_W-2:0], 1'b0};
    data_d.rem_im  = {diff_im[REM_W-2:0], 1'b0};
    data_d.q_re    = {data_i.q_re[NCELL-2:0], ge_re};
    data_d.q_im    = {data_i.q_im[NCELL-2:0], ge_im};
    data_d.sq_src  = {data_i.sq_src[SQ_W-3:0], 2'b00};
    data_d.sq_rem  = srem[SR_W-1:0];
    data_d.sq_root = {data_i.sq_root[NCELL-2:0], sge};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

@@ tb/complex_arithmetic_unit_test.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Complex arithmetic unit testbench
// Drives operand beats through the valid/stall handshake in random bursts,
// stalls the result side on its own pattern with one long hold-off, and
// checks every result beat against an in-order queue of predicted results.
// ----------------------------------------------------------------------------
module complex_arithmetic_unit_test;
  import cau_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int RANDOM_BEATS = 1800;
  localparam int HOLD_CYCLES = 400;

  logic                     clk_i;
  logic                     rst_ni;
  logic                     in_valid_i;
  logic                     in_stall_o;
  logic [2:0]               req_type_i;
  logic signed [DATA_W-1:0] a_re_i;
  logic signed [DATA_W-1:0] a_im_i;
  logic signed [DATA_W-1:0] b_re_i;
  logic signed [DATA_W-1:0] b_im_i;
  logic                     out_valid_o;
  logic                     out_stall_i;
  logic signed [DATA_W-1:0] res_re_o;
  logic signed [DATA_W-1:0] res_im_o;
  logic                     is_equal_o;
  logic [1:0]               status_o;

  complex_arithmetic_unit dut (.*);

  // A directed row; typed rows carry their expected result.
  typedef struct {
    logic [2:0]               op;
    logic signed [DATA_W-1:0] ar;
    logic signed [DATA_W-1:0] ai;
    logic signed [DATA_W-1:0] br;
    logic signed [DATA_W-1:0] bi;
    bit                       typed;
    res_t                     want;
  } vector_t;

  localparam res_t NONE = '{re: 0, im: 0, eq: 0, st: ST_OK};

  vector_t directed [] = '{
    '{OP_ADD, 32767, 0, 1, 0, 1, '{re: 32767, im: 0, eq: 0, st: ST_SAT}},
    '{OP_ADD, -32768, -32768, -1, -1, 1, '{re: -32768, im: -32768, eq: 0, st: ST_SAT}},
    '{OP_SUB, -32768, 32767, 1, -1, 1, '{re: -32768, im: 32767, eq: 0, st: ST_SAT}},
    '{OP_SUB, 0, 0, 0, 0, 1, NONE},
    '{OP_ADD, 256, -256, 512, 0, 0, NONE},
    '{OP_MUL, 256, 0, 256, 0, 1, '{re: 256, im: 0, eq: 0, st: ST_OK}},
    '{OP_MUL, 32767, 32767, 32767, -32767, 0, NONE},
    '{OP_MUL, -32768, -32768, -32768, -32768, 0, NONE},
    '{OP_MUL, 1, 0, 128, 0, 0, NONE},
    '{OP_MUL, -1, 0, 128, 0, 0, NONE},
    '{OP_DIV, 256, 0, 0, 0, 1, '{re: 0, im: 0, eq: 0, st: ST_DIV0}},
    '{OP_DIV, 0, 0, 0, 0, 1, '{re: 0, im: 0, eq: 0, st: ST_DIV0}},
    '{OP_DIV, 256, 256, 256, 0, 0, NONE},
    '{OP_DIV, 32767, 0, 1, 0, 0, NONE},
    '{OP_DIV, -32768, -32768, -32768, -32768, 0, NONE},
    '{OP_DIV, 1, 0, 32767, 32767, 0, NONE},
    '{OP_MAG, -32768, -32768, 0, 0, 0, NONE},
    '{OP_MAG, 768, 1024, 0, 0, 1, '{re: 1280, im: 0, eq: 0, st: ST_OK}},
    '{OP_MAG, 0, 0, 5, 5, 1, NONE},
    '{OP_CMP, 5, -7, 5, -7, 1, '{re: 0, im: 0, eq: 1, st: ST_OK}},
    '{OP_CMP, 5, -7, 5, 7, 1, NONE},
    '{3'd6, -1, -1, -1, -1, 1, NONE},
    '{3'd7, 12, 34, 56, 78, 1, NONE}
  };

  res_t pending_results[$];
  int   cycle_count;
  int   beats_sent;
  int   beats_checked;
  int   error_count;
  int   op_count [8];

  // Clamp a sign/magnitude value to the 16-bit signed range.
  function automatic logic [DATA_W-1:0] clamp_word(input bit neg, input longint unsigned mag,
                                                   inout bit sat);
    if (!neg) begin
      if (mag > 32767) begin
        sat = 1;
        return MAX_POS;
      end
      return mag[DATA_W-1:0];
    end
    if (mag > 32768) begin
      sat = 1;
      return MIN_NEG;
    end
    return DATA_W'(-longint'(mag));
  endfunction

  // Drop the fraction bits of a product, rounding half away from zero.
  function automatic logic [DATA_W-1:0] round_product(input longint p, inout bit sat);
    longint unsigned m;
    m = ((p < 0 ? -p : p) + 128) >> FRAC_W;
    return clamp_word(p < 0 && m != 0, m, sat);
  endfunction

  // One divider lane: num * 2^8 / den, rounded half away from zero.
  function automatic logic [DATA_W-1:0] divide_lane(input longint num, input longint den,
                                                    inout bit sat);
    longint unsigned m, q, r;
    m = (num < 0 ? -num : num) << FRAC_W;
    q = m / den;
    r = m % den;
    if (2 * r >= den) q++;
    return clamp_word(num < 0 && q != 0, q, sat);
  endfunction

  function automatic res_t complex_result(input logic [2:0] op,
                                          input longint ar, input longint ai,
                                          input longint br, input longint bi);
    res_t            r;
    bit              sat;
    longint          den;
    longint unsigned s, root;
    r = NONE;
    sat = 0;
    case (op)
      OP_ADD: begin
        r.re = clamp_word(ar + br < 0, (ar + br < 0) ? -(ar + br) : ar + br, sat);
        r.im = clamp_word(ai + bi < 0, (ai + bi < 0) ? -(ai + bi) : ai + bi, sat);
      end
      OP_SUB: begin
        r.re = clamp_word(ar - br < 0, (ar - br < 0) ? -(ar - br) : ar - br, sat);
        r.im = clamp_word(ai - bi < 0, (ai - bi < 0) ? -(ai - bi) : ai - bi, sat);
      end
      OP_MUL: begin
        r.re = round_product(ar * br - ai * bi, sat);
        r.im = round_product(ar * bi + ai * br, sat);
      end
      OP_DIV: begin
        den = br * br + bi * bi;
        if (den == 0) r.st = ST_DIV0;
        else begin
          r.re = divide_lane(ar * br + ai * bi, den, sat);
          r.im = divide_lane(ai * br - ar * bi, den, sat);
        end
      end
      OP_MAG: begin
        s = ar * ar + ai * ai;
        root = 0;
        for (int i = 16; i >= 0; i--)
          if ((root | (64'd1 << i)) * (root | (64'd1 << i)) <= s) root |= 64'd1 << i;
        if (s - root * root > root) root++;
        r.re = clamp_word(0, root, sat);
      end
      OP_CMP: r.eq = (ar == br) && (ai == bi);
      default: ;
    endcase
    if (sat && r.st == ST_OK) r.st = ST_SAT;
    return r;
  endfunction

  // Offer one beat, hold it until accepted, then queue its expected result.
  task automatic send_beat(input logic [2:0] op, input logic signed [DATA_W-1:0] ar,
                           input logic signed [DATA_W-1:0] ai,
                           input logic signed [DATA_W-1:0] br,
                           input logic signed [DATA_W-1:0] bi,
                           input bit typed, input res_t want);
    in_valid_i <= 1;
    req_type_i <= op;
    a_re_i <= ar;
    a_im_i <= ai;
    b_re_i <= br;
    b_im_i <= bi;
    do @(posedge clk_i); while (in_stall_o);
    pending_results.push_back(typed ? want : complex_result(op, ar, ai, br, bi));
    op_count[op]++;
    beats_sent++;
  endtask

  // Between beats the sender either keeps valid high or idles for a while.
  task automatic sender_gap();
    int gap;
    gap = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 8) : 0;
    if (gap > 0) begin
      in_valid_i <= 0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // Operands weighted toward extremes and small values.
  function automatic logic signed [DATA_W-1:0] pick_operand();
    case ($urandom_range(0, 5))
      0: return MAX_POS - DATA_W'($urandom_range(0, 3));
      1: return MIN_NEG + DATA_W'($urandom_range(0, 3));
      2: return DATA_W'($urandom_range(0, 2047)) - DATA_W'(1024);
      default: return DATA_W'($urandom);
    endcase
  endfunction

  // Free-running clock with an 8 ns period.
  always #4 clk_i = ~clk_i;

  // Timeout guard.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles", cycle_count);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Result side: quiet, light and heavy stall phases, plus one long hold-off.
  initial begin
    bit held;
    int mode;
    held = 0;
    out_stall_i = 0;
    @(posedge rst_ni);
    forever begin
      mode = $urandom_range(0, 2);
      repeat ($urandom_range(20, 100)) begin
        @(posedge clk_i);
        out_stall_i <= (mode == 0) ? 1'b0 :
                       (mode == 1) ? ($urandom_range(0, 3) == 0) : ($urandom_range(0, 1) == 1);
      end
      if (!held && beats_sent > 400) begin
        held = 1;
        @(posedge clk_i);
        out_stall_i <= 1;
        repeat (HOLD_CYCLES) @(posedge clk_i);
      end
    end
  end

  // Compare each result beat with the oldest expectation.
  always @(posedge clk_i) begin
    res_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_results.size() == 0) begin
        $display("%0t: result beat with nothing expected (re %0d im %0d eq %0b st %0d)",
                 $time, res_re_o, res_im_o, is_equal_o, status_o);
        error_count++;
      end else begin
        want = pending_results.pop_front();
        beats_checked++;
        if (res_re_o !== want.re) begin
          $display("%0t: res_re expected %0d actual %0d", $time, want.re, res_re_o);
          error_count++;
        end
        if (res_im_o !== want.im) begin
          $display("%0t: res_im expected %0d actual %0d", $time, want.im, res_im_o);
          error_count++;
        end
        if (is_equal_o !== want.eq) begin
          $display("%0t: is_equal expected %0b actual %0b", $time, want.eq, is_equal_o);
          error_count++;
        end
        if (status_o !== want.st) begin
          $display("%0t: status expected %0d actual %0d", $time, want.st, status_o);
          error_count++;
        end
      end
    end
  end

  // Stimulus: directed table, then random beats in bursts.
  initial begin
    logic [2:0]               op;
    logic signed [DATA_W-1:0] ar, ai, br, bi;
    clk_i = 0;
    rst_ni = 0;
    in_valid_i = 0;
    req_type_i = '0;
    a_re_i = '0;
    a_im_i = '0;
    b_re_i = '0;
    b_im_i = '0;
    cycle_count = 0;
    beats_sent = 0;
    beats_checked = 0;
    error_count = 0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);

    foreach (directed[i]) begin
      send_beat(directed[i].op, directed[i].ar, directed[i].ai, directed[i].br,
                directed[i].bi, directed[i].typed, directed[i].want);
      sender_gap();
    end

    repeat (RANDOM_BEATS) begin
      op = ($urandom_range(0, 40) == 0) ? 3'($urandom_range(6, 7)) : 3'($urandom_range(0, 5));
      ar = pick_operand();
      ai = pick_operand();
      br = pick_operand();
      bi = pick_operand();
      if (op == OP_DIV && $urandom_range(0, 9) == 0) begin
        br = 0;
        bi = 0;
      end
      if (op == OP_CMP && $urandom_range(0, 1) == 1) begin
        br = ar;
        bi = ($urandom_range(0, 2) == 0) ? ai ^ DATA_W'(1 << $urandom_range(0, 15)) : ai;
      end
      send_beat(op, ar, ai, br, bi, 0, NONE);
      sender_gap();
    end
    // Valid is still high only when the last beat was followed by no gap.
    if (in_valid_i) in_valid_i <= 0;

    wait (pending_results.size() == 0);
    repeat (40) @(posedge clk_i);
    $display("Checked %0d of %0d beats: add %0d sub %0d mul %0d div %0d mag %0d cmp %0d",
             beats_checked, beats_sent, op_count[0], op_count[1], op_count[2],
             op_count[3], op_count[4], op_count[5]);
    $display("Unused codes %0d, with bursty input and a long output hold-off",
             op_count[6] + op_count[7]);
    if (error_count == 0 && pending_results.size() == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
